/* design/sdcl_pkg.sv */
package sdcl_pkg;

  localparam int FRAME_BITS = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int TIMEOUT_W  = 20;
  localparam int TRAILER_W  = 8;
  localparam int COUNT_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_CLOCKS = 2'd1;

  localparam logic [TIMEOUT_W-1:0] BUSY_TIMEOUT_RST   = 20'd500000;
  localparam logic [TRAILER_W-1:0] TRAILER_CLOCKS_RST = 8'd16;

  localparam logic [COUNT_W-1:0] SEND_LAST_BIT  = COUNT_W'(FRAME_BITS - 1);
  localparam logic [COUNT_W-1:0] CRC_LAST_BIT   = COUNT_W'(FRAME_BITS - 9);
  localparam logic [COUNT_W-1:0] RESP_SHORT_BITS = COUNT_W'(6 * 8 - 1);
  localparam logic [COUNT_W-1:0] RESP_LONG_BITS  = COUNT_W'(17 * 8 - 1);

  localparam logic [1:0] CMD_PREFIX = 2'b01;
  localparam logic [6:0] CRC7_POLY  = 7'h09;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_READY = 3'd1,
    PH_SEND  = 3'd2,
    PH_START = 3'd3,
    PH_RECV  = 3'd4,
    PH_TRAIL = 3'd5
  } phase_t;

  typedef struct packed {
    logic        mode;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic        long_response;
    logic        cmd_in;
  } in_word_t;

  typedef struct packed {
    logic       cmd_out;
    logic       byte_valid;
    logic [7:0] resp_byte;
    logic       last_byte;
    logic       timeout;
    logic       busy_res;
  } out_word_t;

  function automatic logic [6:0] crc7_step(input logic [6:0] crc, input logic b);
    logic fb;
    fb = crc[6] ^ b;
    return {crc[5:0], 1'b0} ^ (fb ? CRC7_POLY : 7'h00);
  endfunction

endpackage

/* design/sdcl_in_if.sv */
interface sdcl_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [5:0]  cmd_index;
  logic [31:0] argument;
  logic        long_response;
  logic        cmd_in;

  modport source (output valid, mode, cmd_index, argument, long_response, cmd_in,
                  input ready);
  modport sink (input valid, mode, cmd_index, argument, long_response, cmd_in,
                output ready);
endinterface

/* design/sdcl_out_if.sv */
interface sdcl_out_if;
  logic       valid;
  logic       ready;
  logic       cmd_out;
  logic       byte_valid;
  logic [7:0] resp_byte;
  logic       last_byte;
  logic       timeout;
  logic       busy_res;

  modport source (output valid, cmd_out, byte_valid, resp_byte, last_byte, timeout,
                  busy_res, input ready);
  modport sink (input valid, cmd_out, byte_valid, resp_byte, last_byte, timeout,
                busy_res, output ready);
endinterface

/* design/sdcl_cfg_if.sv */
interface sdcl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sdcl_pkg::CFG_IDX_W-1:0]  index;
  logic [sdcl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/sd_cmd_line_engine.sv */
// sd_cmd_line_engine: cmd-line engine of an sd host, one word per sd clock tick.
// in_ch carries words: mode 0 issues a command (index, argument, response length),
// mode 1 is one sd clock tick with the sampled cmd line level in cmd_in.
// out_ch returns exactly one word per input word: the level to drive on cmd,
// a completed response byte with its last flag, a timeout flag and a busy flag.
// cfg_ch writes busy_timeout (index 0) and trailer_clocks (index 1); always ready.
// it is to be written only while the engine is idle; the block itself does not enforce this.
// a word is registered in the input register on acceptance and is processed when it
// advances, which also writes its result into the output register.
// throughput: one word per cycle unless out_ch stalls; the per-tick state update is a
// single pass of short logic between the input register and the output register.
// crc7 of the frame is built one bit per tick while the frame is being sent.
// reset (rst_n low, synchronous) empties both registers, sets the engine idle
// and restores busy_timeout 500000 and trailer_clocks 16.
// when out_ch stalls the output register holds its word, the input register
// still takes one more word, and in_ch.ready drops until out_ch drains.
module sd_cmd_line_engine (
  input  logic       clk,
  input  logic       rst_n,
  sdcl_in_if.sink    in_ch,
  sdcl_out_if.source out_ch,
  sdcl_cfg_if.sink   cfg_ch
);

  logic [sdcl_pkg::TIMEOUT_W-1:0] busy_timeout_r;
  logic [sdcl_pkg::TRAILER_W-1:0] trailer_clocks_r;

  logic                in_valid_r;
  sdcl_pkg::in_word_t  in_r;
  logic                out_valid_r;
  sdcl_pkg::out_word_t out_r;
  logic                advance;
  sdcl_pkg::out_word_t res;

  sdcl_pkg::phase_t phase_r, phase_nxt;
  logic [sdcl_pkg::FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [6:0]                       crc_r, crc_nxt;
  logic [sdcl_pkg::COUNT_W-1:0]    bit_count_r, bit_count_nxt;
  logic [sdcl_pkg::TIMEOUT_W-1:0]  wait_count_r, wait_count_nxt;
  logic [7:0]                       byte_accum_r, byte_accum_nxt;
  logic                             long_flag_r, long_flag_nxt;
  logic [sdcl_pkg::TRAILER_W-1:0]  trailer_count_r, trailer_count_nxt;

  logic                          wait_expired;
  logic [sdcl_pkg::COUNT_W-1:0] bc_dec;
  logic [7:0]                    acc_shift;
  logic [6:0]                    crc_step;

  // handshakes
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cmd_out    = out_r.cmd_out;
  assign out_ch.byte_valid = out_r.byte_valid;
  assign out_ch.resp_byte  = out_r.resp_byte;
  assign out_ch.last_byte  = out_r.last_byte;
  assign out_ch.timeout    = out_r.timeout;
  assign out_ch.busy_res   = out_r.busy_res;

  // shared conditions
  assign wait_expired = (wait_count_r <= sdcl_pkg::TIMEOUT_W'(1));
  assign bc_dec       = (bit_count_r != '0) ? bit_count_r - sdcl_pkg::COUNT_W'(1)
                                            : bit_count_r;
  assign acc_shift    = {byte_accum_r[6:0], in_r.cmd_in};
  assign crc_step     = sdcl_pkg::crc7_step(crc_r, frame_r[sdcl_pkg::FRAME_BITS-1]);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (advance) begin
      if (!in_r.mode) begin
        if (phase_r == sdcl_pkg::PH_IDLE) begin
          phase_nxt = sdcl_pkg::PH_READY;
        end
      end else begin
        case (phase_r)
          sdcl_pkg::PH_IDLE: begin
            phase_nxt = sdcl_pkg::PH_IDLE;
          end
          sdcl_pkg::PH_READY: begin
            if (in_r.cmd_in) begin
              phase_nxt = sdcl_pkg::PH_SEND;
            end else if (wait_expired) begin
              phase_nxt = sdcl_pkg::PH_IDLE;
            end
          end
          sdcl_pkg::PH_SEND: begin
            if (bit_count_r == sdcl_pkg::SEND_LAST_BIT) begin
              phase_nxt = sdcl_pkg::PH_START;
            end
          end
          sdcl_pkg::PH_START: begin
            if (!in_r.cmd_in) begin
              phase_nxt = sdcl_pkg::PH_RECV;
            end else if (wait_expired) begin
              phase_nxt = sdcl_pkg::PH_IDLE;
            end
          end
          sdcl_pkg::PH_RECV: begin
            if (bc_dec == '0) begin
              phase_nxt = (trailer_clocks_r == '0) ? sdcl_pkg::PH_IDLE
                                                   : sdcl_pkg::PH_TRAIL;
            end
          end
          sdcl_pkg::PH_TRAIL: begin
            if (trailer_count_r <= sdcl_pkg::TRAILER_W'(1)) begin
              phase_nxt = sdcl_pkg::PH_IDLE;
            end
          end
          default: begin
            phase_nxt = sdcl_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // datapath and result word
  always_comb begin
    frame_nxt         = frame_r;
    crc_nxt           = crc_r;
    bit_count_nxt     = bit_count_r;
    wait_count_nxt    = wait_count_r;
    byte_accum_nxt    = byte_accum_r;
    long_flag_nxt     = long_flag_r;
    trailer_count_nxt = trailer_count_r;
    res               = '0;
    res.cmd_out       = 1'b1;
    if (advance) begin
      if (!in_r.mode) begin
        if (phase_r == sdcl_pkg::PH_IDLE) begin
          frame_nxt      = {sdcl_pkg::CMD_PREFIX, in_r.cmd_index, in_r.argument, 8'h00};
          crc_nxt        = '0;
          long_flag_nxt  = in_r.long_response;
          bit_count_nxt  = '0;
          byte_accum_nxt = '0;
          wait_count_nxt = busy_timeout_r;
        end else begin
          res.busy_res = 1'b1;
        end
      end else begin
        case (phase_r)
          sdcl_pkg::PH_READY, sdcl_pkg::PH_START: begin
            if ((phase_r == sdcl_pkg::PH_READY) == in_r.cmd_in) begin
              if (phase_r == sdcl_pkg::PH_READY) begin
                bit_count_nxt = '0;
              end else begin
                byte_accum_nxt = '0;
                bit_count_nxt  = long_flag_r ? sdcl_pkg::RESP_LONG_BITS
                                             : sdcl_pkg::RESP_SHORT_BITS;
              end
            end else if (wait_expired) begin
              wait_count_nxt = '0;
              res.timeout    = 1'b1;
            end else begin
              wait_count_nxt = wait_count_r - sdcl_pkg::TIMEOUT_W'(1);
            end
          end
          sdcl_pkg::PH_SEND: begin
            res.cmd_out   = frame_r[sdcl_pkg::FRAME_BITS-1];
            bit_count_nxt = bit_count_r + sdcl_pkg::COUNT_W'(1);
            if (bit_count_r < sdcl_pkg::CRC_LAST_BIT) begin
              crc_nxt   = crc_step;
              frame_nxt = {frame_r[sdcl_pkg::FRAME_BITS-2:0], 1'b0};
            end else if (bit_count_r == sdcl_pkg::CRC_LAST_BIT) begin
              crc_nxt   = crc_step;
              frame_nxt = {crc_step, 1'b1, (sdcl_pkg::FRAME_BITS-8)'(0)};
            end else begin
              frame_nxt = {frame_r[sdcl_pkg::FRAME_BITS-2:0], 1'b0};
            end
            if (bit_count_r == sdcl_pkg::SEND_LAST_BIT) begin
              wait_count_nxt = busy_timeout_r;
            end
          end
          sdcl_pkg::PH_RECV: begin
            bit_count_nxt  = bc_dec;
            byte_accum_nxt = acc_shift;
            if (bc_dec[2:0] == 3'd0) begin
              res.byte_valid = 1'b1;
              res.resp_byte  = acc_shift;
              res.last_byte  = (bc_dec == '0);
              byte_accum_nxt = '0;
            end
            if (bc_dec == '0) begin
              trailer_count_nxt = trailer_clocks_r;
            end
          end
          sdcl_pkg::PH_TRAIL: begin
            if (trailer_count_r != '0) begin
              trailer_count_nxt = trailer_count_r - sdcl_pkg::TRAILER_W'(1);
            end
          end
          default: begin
            res.cmd_out = 1'b1;
          end
        endcase
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      phase_r          <= sdcl_pkg::PH_IDLE;
      busy_timeout_r   <= sdcl_pkg::BUSY_TIMEOUT_RST;
      trailer_clocks_r <= sdcl_pkg::TRAILER_CLOCKS_RST;
    end else begin
      phase_r <= phase_nxt;
      if (in_ch.valid && in_ch.ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          sdcl_pkg::CFG_BUSY_TIMEOUT: begin
            busy_timeout_r <= cfg_ch.data[sdcl_pkg::TIMEOUT_W-1:0];
          end
          sdcl_pkg::CFG_TRAILER_CLOCKS: begin
            trailer_clocks_r <= cfg_ch.data[sdcl_pkg::TRAILER_W-1:0];
          end
          default: begin
            trailer_clocks_r <= trailer_clocks_r;
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.mode          <= in_ch.mode;
      in_r.cmd_index     <= in_ch.cmd_index;
      in_r.argument      <= in_ch.argument;
      in_r.long_response <= in_ch.long_response;
      in_r.cmd_in        <= in_ch.cmd_in;
    end
    if (advance) begin
      out_r <= res;
    end
    frame_r         <= frame_nxt;
    crc_r           <= crc_nxt;
    bit_count_r     <= bit_count_nxt;
    wait_count_r    <= wait_count_nxt;
    byte_accum_r    <= byte_accum_nxt;
    long_flag_r     <= long_flag_nxt;
    trailer_count_r <= trailer_count_nxt;
  end

  a_issue_starts: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !in_r.mode && phase_r == sdcl_pkg::PH_IDLE
    |=> phase_r == sdcl_pkg::PH_READY)
    else $error("issue from idle did not start the ready wait");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_r.mode && phase_r == sdcl_pkg::PH_SEND
    && bit_count_r == sdcl_pkg::SEND_LAST_BIT
    |=> phase_r == sdcl_pkg::PH_START)
    else $error("frame end did not move to start bit wait");

  a_recv_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sdcl_pkg::PH_RECV |-> bit_count_r != '0)
    else $error("receive phase with an empty bit count");

  a_last_byte_ends: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.last_byte
    |=> phase_r == sdcl_pkg::PH_TRAIL || phase_r == sdcl_pkg::PH_IDLE)
    else $error("last response byte did not end the receive phase");

endmodule
